FILE: rtl/core/green_cast_reducer_assert.svh
// Assertion macros used by the green cast reducer checker.
`ifndef GREEN_CAST_REDUCER_ASSERT_SVH
`define GREEN_CAST_REDUCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define GCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("green_cast_reducer: check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define GCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("green_cast_reducer: check failed");

`endif

FILE: rtl/core/gcr_pkg.sv
// Types, constants and helpers shared by the green cast reducer modules.
`default_nettype none

package gcr_pkg;

  localparam int unsigned NumStages = 8;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [16:0] StrengthOne = 17'h10000;
  localparam logic [15:0] FullScale8  = 16'd255;
  localparam logic [15:0] FullScale16 = 16'hFFFF;

  localparam logic [1:0] RegIdxMode     = 2'd0;
  localparam logic [1:0] RegIdxStrength = 2'd1;
  localparam logic [1:0] RegIdxEight    = 2'd2;

  typedef enum logic [1:0] {
    MODE_AVG_NEUTRAL = 2'd0,
    MODE_MAX_NEUTRAL = 2'd1,
    MODE_MAX_MASK    = 2'd2,
    MODE_ADD_MASK    = 2'd3
  } gcr_mode_e;

  typedef struct packed {
    gcr_mode_e   mode;
    logic [16:0] strength;
    logic        eight_bit_image;
  } gcr_cfg_t;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        frame_end_in;
  } gcr_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        frame_end_out;
  } gcr_out_t;

  // Sample data that rides along the pipeline next to the arithmetic.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        frame_end;
    logic [15:0] neutral;
  } gcr_carry_t;

  // Mask terms handed from the front end to the multiplier stages.
  typedef struct packed {
    logic [15:0] mask;
    logic [15:0] headroom;
    logic [16:0] keep;
  } gcr_mask_t;

  function automatic logic [15:0] full_scale(input logic eight_bit);
    full_scale = eight_bit ? FullScale8 : FullScale16;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gcr_cfg_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module gcr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gcr_pkg::AddrWidth-1:0]        paddr,
  input  logic [gcr_pkg::DataWidth-1:0]        pwdata,
  output logic [gcr_pkg::DataWidth-1:0]        prdata,
  output logic                                 pready,
  output gcr_pkg::gcr_cfg_t                    cfg_o
);

  gcr_pkg::gcr_cfg_t cfg_q;
  gcr_pkg::gcr_cfg_t cfg_d;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[gcr_pkg::AddrWidth-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        gcr_pkg::RegIdxMode:     cfg_d.mode = gcr_pkg::gcr_mode_e'(pwdata[1:0]);
        gcr_pkg::RegIdxStrength: cfg_d.strength = pwdata[16:0];
        gcr_pkg::RegIdxEight:    cfg_d.eight_bit_image = pwdata[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: gcr_pkg::MODE_AVG_NEUTRAL,
                 strength: gcr_pkg::StrengthOne,
                 eight_bit_image: 1'b0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      gcr_pkg::RegIdxMode:     prdata = {30'd0, cfg_q.mode};
      gcr_pkg::RegIdxStrength: prdata = {15'd0, cfg_q.strength};
      gcr_pkg::RegIdxEight:    prdata = {31'd0, cfg_q.eight_bit_image};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/core/gcr_front.sv
// Front end: sample saturation, then neutral result and mask terms.
`default_nettype none

module gcr_front (
  input  logic                  clk_i,
  input  logic [1:0]            en_i,
  input  gcr_pkg::gcr_cfg_t     cfg_i,
  input  gcr_pkg::gcr_in_t      in_data_i,
  output gcr_pkg::gcr_carry_t   carry_o,
  output gcr_pkg::gcr_mask_t    mask_o
);

  logic [15:0]         fs;
  gcr_pkg::gcr_carry_t s1_d;
  gcr_pkg::gcr_carry_t s1_q;
  gcr_pkg::gcr_carry_t s2_d;
  gcr_pkg::gcr_carry_t s2_q;
  gcr_pkg::gcr_mask_t  mask_d;
  gcr_pkg::gcr_mask_t  mask_q;
  logic [15:0]         max_rb;
  logic [16:0]         sum_rb;
  logic [16:0]         sum_rnd;
  logic [15:0]         avg_rb;
  logic [16:0]         strength_sat;

  assign fs = gcr_pkg::full_scale(cfg_i.eight_bit_image);

  // Stage 1: clip every sample to full scale.
  always_comb begin
    s1_d.red       = (in_data_i.red_in   > fs) ? fs : in_data_i.red_in;
    s1_d.green     = (in_data_i.green_in > fs) ? fs : in_data_i.green_in;
    s1_d.blue      = (in_data_i.blue_in  > fs) ? fs : in_data_i.blue_in;
    s1_d.frame_end = in_data_i.frame_end_in;
    s1_d.neutral   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_q <= s1_d;
    end
  end

  // Stage 2: neutral-mode green and the mask for the mixing modes.
  always_comb begin
    max_rb       = (s1_q.red > s1_q.blue) ? s1_q.red : s1_q.blue;
    sum_rb       = {1'b0, s1_q.red} + {1'b0, s1_q.blue};
    sum_rnd      = sum_rb + 17'd1;
    avg_rb       = sum_rnd[16:1];
    strength_sat = (cfg_i.strength > gcr_pkg::StrengthOne) ? gcr_pkg::StrengthOne
                                                           : cfg_i.strength;
    s2_d = s1_q;
    if (cfg_i.mode == gcr_pkg::MODE_AVG_NEUTRAL) begin
      s2_d.neutral = (s1_q.green < avg_rb) ? s1_q.green : avg_rb;
    end else begin
      s2_d.neutral = (s1_q.green < max_rb) ? s1_q.green : max_rb;
    end
    if (cfg_i.mode == gcr_pkg::MODE_MAX_MASK) begin
      mask_d.mask = max_rb;
    end else begin
      mask_d.mask = (sum_rb > {1'b0, fs}) ? fs : sum_rb[15:0];
    end
    mask_d.headroom = fs - mask_d.mask;
    mask_d.keep     = gcr_pkg::StrengthOne - strength_sat;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_q   <= s2_d;
      mask_q <= mask_d;
    end
  end

  assign carry_o = s2_q;
  assign mask_o  = mask_q;

endmodule

`default_nettype wire

FILE: rtl/core/gcr_scale_mul.sv
// Multiplier stages: build the mixing weight and scale green by it.
`default_nettype none

module gcr_scale_mul (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  gcr_pkg::gcr_cfg_t     cfg_i,
  input  gcr_pkg::gcr_carry_t   carry_i,
  input  gcr_pkg::gcr_mask_t    mask_i,
  output gcr_pkg::gcr_carry_t   carry_o,
  output logic [31:0]           quot_num_o
);

  gcr_pkg::gcr_carry_t s3_q;
  gcr_pkg::gcr_carry_t s4_q;
  gcr_pkg::gcr_carry_t s5_q;
  logic [32:0]         keep_prod;
  logic [31:0]         keep_prod_q;
  logic [15:0]         mask_q;
  logic [31:0]         weight_d;
  logic [31:0]         weight_q;
  logic [15:0]         fs;
  logic [47:0]         scaled;
  logic [31:0]         quot_num_q;

  assign fs = gcr_pkg::full_scale(cfg_i.eight_bit_image);

  // Stage 3: (1 - amount) * (F - m), in units of 1/65536.
  assign keep_prod = {16'd0, mask_i.keep} * {17'd0, mask_i.headroom};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s3_q        <= carry_i;
      keep_prod_q <= keep_prod[31:0];
      mask_q      <= mask_i.mask;
    end
  end

  // Stage 4: add the mask term; the weight never exceeds 65536 * F.
  assign weight_d = keep_prod_q + {mask_q, 16'd0};

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s4_q     <= s3_q;
      weight_q <= weight_d;
    end
  end

  // Stage 5: g * weight plus half of 65536 * F, then drop the 65536 factor.
  // Flooring twice equals flooring once, so what remains is a plain divide by F.
  assign scaled = {32'd0, s4_q.green} * {16'd0, weight_q}
                + {17'd0, fs, 15'd0};

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s5_q       <= s4_q;
      quot_num_q <= scaled[47:16];
    end
  end

  assign carry_o    = s5_q;
  assign quot_num_o = quot_num_q;

endmodule

`default_nettype wire

FILE: rtl/core/gcr_div_fs.sv
// Divide by full scale (2^k - 1), correct the estimate, pick the result.
`default_nettype none

module gcr_div_fs (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  gcr_pkg::gcr_cfg_t     cfg_i,
  input  gcr_pkg::gcr_carry_t   carry_i,
  input  logic [31:0]           quot_num_i,
  output gcr_pkg::gcr_out_t     out_data_o
);

  gcr_pkg::gcr_carry_t s6_q;
  gcr_pkg::gcr_carry_t s7_q;
  logic [32:0]         est_sum;
  logic [16:0]         est_d;
  logic [16:0]         est_q;
  logic [16:0]         est7_q;
  logic [31:0]         num6_q;
  logic [32:0]         est_mul;
  logic [32:0]         rem_full;
  logic [17:0]         rem_q;
  logic [15:0]         fs;
  logic [17:0]         fs_x1;
  logic [17:0]         fs_x2;
  logic [16:0]         quot;
  logic [15:0]         green_mix;
  gcr_pkg::gcr_out_t   out_d;
  gcr_pkg::gcr_out_t   out_q;

  assign fs    = gcr_pkg::full_scale(cfg_i.eight_bit_image);
  assign fs_x1 = {2'b00, fs};
  assign fs_x2 = {1'b0, fs, 1'b0};

  // Stage 6: y / (2^k - 1) is close to (y + y >> k) >> k, at most two low.
  always_comb begin
    if (cfg_i.eight_bit_image) begin
      est_sum = {1'b0, quot_num_i} + {9'd0, quot_num_i[31:8]};
      est_d   = est_sum[24:8];
    end else begin
      est_sum = {1'b0, quot_num_i} + {17'd0, quot_num_i[31:16]};
      est_d   = est_sum[32:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s6_q   <= carry_i;
      est_q  <= est_d;
      num6_q <= quot_num_i;
    end
  end

  // Stage 7: remainder of the estimate, below three times full scale.
  always_comb begin
    if (cfg_i.eight_bit_image) begin
      est_mul = {8'd0, est_q, 8'd0} - {16'd0, est_q};
    end else begin
      est_mul = {est_q, 16'd0} - {16'd0, est_q};
    end
    rem_full = {1'b0, num6_q} - est_mul;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s7_q   <= s6_q;
      est7_q <= est_q;
      rem_q  <= rem_full[17:0];
    end
  end

  // Stage 8: correct the quotient, clamp, and choose by mode.
  always_comb begin
    if (rem_q >= fs_x2) begin
      quot = est7_q + 17'd2;
    end else if (rem_q >= fs_x1) begin
      quot = est7_q + 17'd1;
    end else begin
      quot = est7_q;
    end
    green_mix = (quot > {1'b0, fs}) ? fs : quot[15:0];
    out_d.red_out       = s7_q.red;
    out_d.blue_out      = s7_q.blue;
    out_d.frame_end_out = s7_q.frame_end;
    if (cfg_i.mode == gcr_pkg::MODE_AVG_NEUTRAL
        || cfg_i.mode == gcr_pkg::MODE_MAX_NEUTRAL) begin
      out_d.green_out = s7_q.neutral;
    end else begin
      out_d.green_out = green_mix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/green_cast_reducer.sv
// Top level of the green cast reducer: config port, pipeline control, datapath.
//
//   Channel  Direction  Handshake                  Payload
//   in       sink       in_valid_i / in_stall_o    in_data_i   (gcr_in_t)
//   out      source     out_valid_o / out_stall_i  out_data_o  (gcr_out_t)
//   config   sink       psel, penable, pwrite      paddr, pwdata, prdata
//
// One pixel beat is taken every clock unless in_stall_o is high; each beat passes
// through the eight register stages of the datapath (saturate, mask, two
// multiplier stages with an add between, divide estimate, remainder, fix).
// Reset empties the pipeline and loads the register reset values.
// Every stage has its own valid bit and loads while it is empty or the stage
// after it moves, so a stalled output holds its beat and any bubbles behind it
// are squeezed out before the input side is stalled.
`default_nettype none

module green_cast_reducer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gcr_pkg::AddrWidth-1:0]  paddr,
  input  logic [gcr_pkg::DataWidth-1:0]  pwdata,
  output logic [gcr_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gcr_pkg::gcr_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gcr_pkg::gcr_out_t              out_data_o
);

  localparam int unsigned Last = gcr_pkg::NumStages - 1;

  gcr_pkg::gcr_cfg_t                 cfg;
  logic [gcr_pkg::NumStages-1:0]     valid_q;
  logic [gcr_pkg::NumStages-1:0]     valid_d;
  logic [gcr_pkg::NumStages-1:0]     stage_en;
  gcr_pkg::gcr_carry_t               front_carry;
  gcr_pkg::gcr_mask_t                front_mask;
  gcr_pkg::gcr_carry_t               mul_carry;
  logic [31:0]                       quot_num;

  gcr_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    stage_en[Last] = !valid_q[Last] || !out_stall_i;
    for (int i = Last - 1; i >= 0; i--) begin
      stage_en[i] = !valid_q[i] || stage_en[i+1];
    end
    for (int i = 0; i < gcr_pkg::NumStages; i++) begin
      if (stage_en[i]) begin
        valid_d[i] = (i == 0) ? in_valid_i : valid_q[(i == 0) ? 0 : i - 1];
      end else begin
        valid_d[i] = valid_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  gcr_front u_front (
    .clk_i     (clk_i),
    .en_i      (stage_en[1:0]),
    .cfg_i     (cfg),
    .in_data_i (in_data_i),
    .carry_o   (front_carry),
    .mask_o    (front_mask)
  );

  gcr_scale_mul u_scale_mul (
    .clk_i      (clk_i),
    .en_i       (stage_en[4:2]),
    .cfg_i      (cfg),
    .carry_i    (front_carry),
    .mask_i     (front_mask),
    .carry_o    (mul_carry),
    .quot_num_o (quot_num)
  );

  gcr_div_fs u_div_fs (
    .clk_i      (clk_i),
    .en_i       (stage_en[7:5]),
    .cfg_i      (cfg),
    .carry_i    (mul_carry),
    .quot_num_i (quot_num),
    .out_data_o (out_data_o)
  );

  assign in_stall_o  = !stage_en[0];
  assign out_valid_o = valid_q[Last];

endmodule

`default_nettype wire

FILE: rtl/core/gcr_checker.sv
// Port-level checks for the green cast reducer, bound to the top level.
`default_nettype none

`include "green_cast_reducer_assert.svh"

module gcr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input gcr_pkg::gcr_out_t out_data_o
);

  logic       in_beat;
  logic       out_free;
  logic [6:0] free_hist_q;

  assign in_beat  = rst_ni && in_valid_i && !in_stall_o;
  assign out_free = rst_ni && !out_stall_i;

  // Output-free history in a seven-bit shift register, newest in bit zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_hist_q <= '0;
    end else begin
      free_hist_q <= {free_hist_q[5:0], out_free};
    end
  end

  // A stalled output beat stays put.
  `GCR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // With nothing blocking the output, the input side is never stalled.
  `GCR_ASSERT_NOW(a_in_free, !out_valid_o || !out_stall_i, !in_stall_o)

  // A beat taken while the output stays free is then presented as a valid output beat.
  `GCR_ASSERT_NOW(a_latency, $past(in_beat, 8) && (&free_hist_q), out_valid_o)

endmodule

bind green_cast_reducer gcr_checker u_gcr_checker (.*);

`default_nettype wire
